// ----- rtl/gradient_non_maximum_suppression_core_assert.svh -----
// Assertion macros shared by the gradient non-maximum suppression RTL.
// Depends on nothing; define SYNTH to compile the checks away.
`ifndef GRADIENT_NON_MAXIMUM_SUPPRESSION_CORE_ASSERT_SVH
`define GRADIENT_NON_MAXIMUM_SUPPRESSION_CORE_ASSERT_SVH
`ifndef SYNTH
`define GNMS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gnms assertion failed");
`define GNMS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("gnms forbidden condition seen");
`else
`define GNMS_ASSERT(lbl, clk, rst_n, prop)
`define GNMS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- rtl/gnms_pkg.sv -----
// Package for the gradient non-maximum suppression core: constants, register
// indexes, position struct and item width helper. No dependencies.
package gnms_pkg;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int DEF_MAG_BITS  = 16;
    localparam int DEF_GRAD_BITS = 16;

    localparam int ROW_BITS    = 12;
    localparam int COL_BITS    = 11;
    localparam int WIDTH_BITS  = 12;
    localparam int HEIGHT_BITS = 13;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_LIMIT = 13'd4096;
    localparam int DIM_MIN = 3;

    localparam int DIAG_WEIGHT = 23170;
    localparam int AXIS_SHIFT  = 15;
    localparam logic [7:0] EDGE_VALUE = 8'd255;
    localparam logic [7:0] NO_EDGE    = 8'd0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] column;
        logic                last;
    } t_pos;

    function automatic int item_width(input int mag_bits, input int grad_bits);
        return 9 * mag_bits + 2 * grad_bits + $bits(t_pos);
    endfunction

endpackage

// ----- rtl/gradient_non_maximum_suppression_core.sv -----
// 3x3 gradient non-maximum suppression over a raster pixel stream. One pixel is taken per
// clock when nothing stalls downstream; the rate is set by the two line-store RAMs, each read
// at intake and written back in the cycle after. A result passes the RAM read, window and
// queue, scoring and neighbor select; stalls can hold it. Border pixels give no result.
// The line stores hold no reset value and have no clearing pass, so they are ready at once.
// Depends on gnms_pkg, gnms_front, gnms_fifo, gnms_back and gnms_ram.
module gradient_non_maximum_suppression_core #(
    parameter int MAX_WIDTH = gnms_pkg::DEF_MAX_WIDTH,
    parameter int MAG_BITS  = gnms_pkg::DEF_MAG_BITS,
    parameter int GRAD_BITS = gnms_pkg::DEF_GRAD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [MAG_BITS-1:0]                 i_magnitude,
    input  logic signed [GRAD_BITS-1:0]         i_grad_x,
    input  logic signed [GRAD_BITS-1:0]         i_grad_y,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [gnms_pkg::ROW_BITS-1:0]       o_row,
    output logic [gnms_pkg::COL_BITS-1:0]       o_column,
    output logic [7:0]                          o_edge_res,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gnms_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [gnms_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import gnms_pkg::*;

    localparam int ITEM_W = item_width(MAG_BITS, GRAD_BITS);

    logic                 q_push;
    logic                 q_pop;
    logic [ITEM_W-1:0]    q_wdata;
    logic [ITEM_W-1:0]    q_rdata;
    logic [QCNT_BITS-1:0] q_count;

    assign o_cfg_ready = 1'b1;

    gnms_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAG_BITS  (MAG_BITS),
        .GRAD_BITS (GRAD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_magnitude (i_magnitude),
        .i_grad_x    (i_grad_x),
        .i_grad_y    (i_grad_y),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_count   (q_count),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    gnms_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_count (q_count)
    );

    gnms_back #(
        .MAG_BITS  (MAG_BITS),
        .GRAD_BITS (GRAD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (q_rdata),
        .i_q_count  (q_count),
        .o_q_pop    (q_pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_row      (o_row),
        .o_column   (o_column),
        .o_edge_res (o_edge_res),
        .o_last     (o_last)
    );
endmodule

// ----- rtl/gnms_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module gnms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/gnms_fifo.sv -----
// Short register queue between the window front end and the suppression back end.
// No dependencies.
module gnms_fifo #(
    parameter int WIDTH = 200,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_data,
    input  logic                           i_pop,
    output logic [WIDTH-1:0]               o_data,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;
endmodule

// ----- rtl/gnms_front.sv -----
// Front end: pixel intake, raster counters, configuration, line stores and 3x3 window.
// Depends on gnms_pkg, gnms_ram and the assertion macro header.
`include "gradient_non_maximum_suppression_core_assert.svh"
module gnms_front #(
    parameter int MAX_WIDTH = gnms_pkg::DEF_MAX_WIDTH,
    parameter int MAG_BITS  = gnms_pkg::DEF_MAG_BITS,
    parameter int GRAD_BITS = gnms_pkg::DEF_GRAD_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [MAG_BITS-1:0]                   i_magnitude,
    input  logic signed [GRAD_BITS-1:0]           i_grad_x,
    input  logic signed [GRAD_BITS-1:0]           i_grad_y,
    input  logic                                  i_cfg_we,
    input  logic [gnms_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [gnms_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic [gnms_pkg::QCNT_BITS-1:0]        i_q_count,
    output logic                                  o_q_push,
    output logic [gnms_pkg::item_width(MAG_BITS, GRAD_BITS)-1:0] o_q_data
);
    import gnms_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    typedef struct packed {
        logic [MAG_BITS-1:0]        ctr_mag;
        logic [7:0][MAG_BITS-1:0]   nb_mag;
        logic signed [GRAD_BITS-1:0] gx;
        logic signed [GRAD_BITS-1:0] gy;
        t_pos                       pos;
    } t_item;

    logic [WIDTH_BITS-1:0]  r_width, n_width;
    logic [HEIGHT_BITS-1:0] r_height, n_height;
    logic [ROW_BITS-1:0]    r_row, n_row;
    logic [CW-1:0]          r_col, n_col;

    logic                          r_s1_valid;
    logic                          r_s1_emit;
    logic [CW-1:0]                 r_s1_addr;
    logic [MAG_BITS-1:0]           r_s1_mag;
    logic signed [GRAD_BITS-1:0]   r_s1_gx;
    logic signed [GRAD_BITS-1:0]   r_s1_gy;
    t_pos                          r_s1_pos;

    logic [MAG_BITS-1:0]           r_win_mag [3][2];
    logic signed [GRAD_BITS-1:0]   r_ctr_gx;
    logic signed [GRAD_BITS-1:0]   r_ctr_gy;

    logic                          acc;
    logic                          row_end;
    logic                          frame_end;
    logic                          emit;
    t_pos                          pos;
    logic [WIDTH_BITS-1:0]         cfg_w;
    logic [HEIGHT_BITS-1:0]        cfg_h;

    logic [2*MAG_BITS-1:0]         mag_rd;
    logic [2*GRAD_BITS-1:0]        grad_rd;
    logic [MAG_BITS-1:0]           rd_older;
    logic [MAG_BITS-1:0]           rd_newer;
    t_item                         item;

    assign o_stall = (32'(i_q_count) + 32'(r_s1_valid)) >= QUEUE_DEPTH;
    assign acc     = i_valid && !o_stall;

    assign row_end   = 32'(r_col) >= (32'(r_width) - 32'd1);
    assign frame_end = row_end && (32'(r_row) >= (32'(r_height) - 32'd1));
    assign emit      = (32'(r_row) >= 32'd2) && (32'(r_col) >= 32'd2);

    always_comb begin
        pos.row    = r_row - ROW_BITS'(1);
        pos.column = COL_BITS'(32'(r_col) - 32'd1);
        pos.last   = frame_end;
    end

    always_comb begin
        cfg_w = i_cfg_data[WIDTH_BITS-1:0];
        cfg_h = i_cfg_data[HEIGHT_BITS-1:0];
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we && i_cfg_index == REG_IMAGE_WIDTH) begin
            if (32'(cfg_w) < DIM_MIN) begin
                n_width = WIDTH_BITS'(DIM_MIN);
            end else if (32'(cfg_w) > MAX_WIDTH) begin
                n_width = WIDTH_BITS'(MAX_WIDTH);
            end else begin
                n_width = cfg_w;
            end
        end
        if (i_cfg_we && i_cfg_index == REG_IMAGE_HEIGHT) begin
            if (32'(cfg_h) < DIM_MIN) begin
                n_height = HEIGHT_BITS'(DIM_MIN);
            end else if (cfg_h > HEIGHT_LIMIT) begin
                n_height = HEIGHT_LIMIT;
            end else begin
                n_height = cfg_h;
            end
        end
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (acc) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : r_row + ROW_BITS'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WIDTH_RESET;
            r_height   <= HEIGHT_RESET;
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_width    <= n_width;
            r_height   <= n_height;
            r_row      <= n_row;
            r_col      <= n_col;
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_emit <= emit;
            r_s1_addr <= r_col;
            r_s1_mag  <= i_magnitude;
            r_s1_gx   <= i_grad_x;
            r_s1_gy   <= i_grad_y;
            r_s1_pos  <= pos;
        end
    end

    gnms_ram #(
        .WIDTH (2 * MAG_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_mag_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata ({rd_newer, r_s1_mag}),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (mag_rd)
    );

    gnms_ram #(
        .WIDTH (2 * GRAD_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_grad_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata ({r_s1_gx, r_s1_gy}),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (grad_rd)
    );

    assign rd_older = mag_rd[2*MAG_BITS-1:MAG_BITS];
    assign rd_newer = mag_rd[MAG_BITS-1:0];

    // shift the window one column; the incoming column enters on the right
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win_mag[k][0] <= r_win_mag[k][1];
            end
            r_win_mag[0][1] <= rd_older;
            r_win_mag[1][1] <= rd_newer;
            r_win_mag[2][1] <= r_s1_mag;
            r_ctr_gx        <= $signed(grad_rd[2*GRAD_BITS-1:GRAD_BITS]);
            r_ctr_gy        <= $signed(grad_rd[GRAD_BITS-1:0]);
        end
    end

    always_comb begin
        item.ctr_mag   = r_win_mag[1][1];
        item.nb_mag[0] = r_win_mag[0][0];
        item.nb_mag[1] = r_win_mag[1][0];
        item.nb_mag[2] = r_win_mag[2][0];
        item.nb_mag[3] = r_win_mag[0][1];
        item.nb_mag[4] = r_win_mag[2][1];
        item.nb_mag[5] = rd_older;
        item.nb_mag[6] = rd_newer;
        item.nb_mag[7] = r_s1_mag;
        item.gx        = r_ctr_gx;
        item.gy        = r_ctr_gy;
        item.pos       = r_s1_pos;
    end

    assign o_q_push = r_s1_valid && r_s1_emit;
    assign o_q_data = item;

    `GNMS_ASSERT_NEVER(a_queue_credit, i_clk, i_rst_n, (32'(i_q_count) + 32'(r_s1_valid)) > QUEUE_DEPTH)
    `GNMS_ASSERT(a_frame_wrap, i_clk, i_rst_n, acc && frame_end |=> r_row == '0 && r_col == '0)
    `GNMS_ASSERT(a_col_advance, i_clk, i_rst_n, acc && !row_end |=> 32'(r_col) == 32'($past(r_col)) + 32'd1)
endmodule

// ----- rtl/gnms_back.sv -----
// Back end: scores the eight neighbors, picks best aligned and most opposed, and
// drives the registered result. Depends on gnms_pkg.
module gnms_back #(
    parameter int MAG_BITS  = gnms_pkg::DEF_MAG_BITS,
    parameter int GRAD_BITS = gnms_pkg::DEF_GRAD_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [gnms_pkg::item_width(MAG_BITS, GRAD_BITS)-1:0] i_q_data,
    input  logic [gnms_pkg::QCNT_BITS-1:0]         i_q_count,
    output logic                                   o_q_pop,
    input  logic                                   i_stall,
    output logic                                   o_valid,
    output logic [gnms_pkg::ROW_BITS-1:0]          o_row,
    output logic [gnms_pkg::COL_BITS-1:0]          o_column,
    output logic [7:0]                             o_edge_res,
    output logic                                   o_last
);
    import gnms_pkg::*;

    localparam int SW = GRAD_BITS + 16;
    localparam logic signed [SW-1:0] DIAG_K = SW'(DIAG_WEIGHT);

    typedef struct packed {
        logic [MAG_BITS-1:0]         ctr_mag;
        logic [7:0][MAG_BITS-1:0]    nb_mag;
        logic signed [GRAD_BITS-1:0] gx;
        logic signed [GRAD_BITS-1:0] gy;
        t_pos                        pos;
    } t_item;

    typedef struct packed {
        logic signed [SW-1:0] score;
        logic [MAG_BITS-1:0]  mag;
    } t_cand;

    t_item                       head;
    logic                        en;
    logic signed [GRAD_BITS:0]   sum_p;
    logic signed [GRAD_BITS:0]   sum_m;

    logic                        r_b1_valid;
    logic signed [SW-1:0]        r_b1_d1;
    logic signed [SW-1:0]        r_b1_d2;
    logic signed [GRAD_BITS-1:0] r_b1_gx;
    logic signed [GRAD_BITS-1:0] r_b1_gy;
    logic [7:0][MAG_BITS-1:0]    r_b1_nb;
    logic [MAG_BITS-1:0]         r_b1_ctr;
    logic                        r_b1_zero;
    t_pos                        r_b1_pos;

    logic signed [SW-1:0]        ax;
    logic signed [SW-1:0]        ay;
    t_cand                       sc [8];
    t_cand                       mx1 [4];
    t_cand                       mn1 [4];
    t_cand                       mx2 [2];
    t_cand                       mn2 [2];

    logic                        r_b2_valid;
    t_cand                       r_b2_max [2];
    t_cand                       r_b2_min [2];
    logic [MAG_BITS-1:0]         r_b2_ctr;
    logic                        r_b2_zero;
    t_pos                        r_b2_pos;

    t_cand                       best;
    t_cand                       worst;
    logic [7:0]                  n_edge;

    logic                        r_out_valid;
    logic [7:0]                  r_out_edge;
    t_pos                        r_out_pos;

    assign head    = i_q_data;
    assign en      = !r_out_valid || !i_stall;
    assign o_q_pop = en && (i_q_count != '0);

    assign sum_p = (GRAD_BITS+1)'(head.gx) + (GRAD_BITS+1)'(head.gy);
    assign sum_m = (GRAD_BITS+1)'(head.gx) - (GRAD_BITS+1)'(head.gy);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_d1   <= SW'(sum_p) * DIAG_K;
            r_b1_d2   <= SW'(sum_m) * DIAG_K;
            r_b1_gx   <= head.gx;
            r_b1_gy   <= head.gy;
            r_b1_nb   <= head.nb_mag;
            r_b1_ctr  <= head.ctr_mag;
            r_b1_zero <= (head.gx == '0) && (head.gy == '0);
            r_b1_pos  <= head.pos;
        end
    end

    // neighbors in scan order; ties keep the earlier neighbor
    always_comb begin
        ax = SW'(r_b1_gx) <<< AXIS_SHIFT;
        ay = SW'(r_b1_gy) <<< AXIS_SHIFT;
        sc[0].score = -r_b1_d1;
        sc[1].score = -ax;
        sc[2].score = -r_b1_d2;
        sc[3].score = -ay;
        sc[4].score = ay;
        sc[5].score = r_b1_d2;
        sc[6].score = ax;
        sc[7].score = r_b1_d1;
        for (int k = 0; k < 8; k++) begin
            sc[k].mag = r_b1_nb[k];
        end
        for (int i = 0; i < 4; i++) begin
            mx1[i] = (sc[2*i+1].score > sc[2*i].score) ? sc[2*i+1] : sc[2*i];
            mn1[i] = (sc[2*i+1].score < sc[2*i].score) ? sc[2*i+1] : sc[2*i];
        end
        for (int j = 0; j < 2; j++) begin
            mx2[j] = (mx1[2*j+1].score > mx1[2*j].score) ? mx1[2*j+1] : mx1[2*j];
            mn2[j] = (mn1[2*j+1].score < mn1[2*j].score) ? mn1[2*j+1] : mn1[2*j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b2_max  <= mx2;
            r_b2_min  <= mn2;
            r_b2_ctr  <= r_b1_ctr;
            r_b2_zero <= r_b1_zero;
            r_b2_pos  <= r_b1_pos;
        end
    end

    always_comb begin
        best   = (r_b2_max[1].score > r_b2_max[0].score) ? r_b2_max[1] : r_b2_max[0];
        worst  = (r_b2_min[1].score < r_b2_min[0].score) ? r_b2_min[1] : r_b2_min[0];
        n_edge = (!r_b2_zero && (r_b2_ctr > best.mag) && (r_b2_ctr > worst.mag))
                 ? EDGE_VALUE : NO_EDGE;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_edge <= n_edge;
            r_out_pos  <= r_b2_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_b1_valid  <= o_q_pop;
            r_b2_valid  <= r_b1_valid;
            r_out_valid <= r_b2_valid;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_row      = r_out_pos.row;
    assign o_column   = r_out_pos.column;
    assign o_edge_res = r_out_edge;
    assign o_last     = r_out_pos.last;
endmodule

// ----- bench/gradient_non_maximum_suppression_core_test.sv -----
// Self-checking bench for gradient_non_maximum_suppression_core: raster pixels in,
// 3x3 directional edge masks out, checked against an in-bench scoring model.
// Depends on gnms_pkg and the core RTL.
module gradient_non_maximum_suppression_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gnms_pkg::*;

    localparam int MAG_W = DEF_MAG_BITS;
    localparam int GRAD_W = DEF_GRAD_BITS;
    localparam int MAX_COLS = DEF_MAX_WIDTH;
    localparam int CLK_HALF = 5;
    localparam int RESET_CYCLES = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 400;
    localparam longint AXIS_WEIGHT = longint'(1) << AXIS_SHIFT;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {TEX_FULL, TEX_TIES, TEX_EXTREME, TEX_SPARSE} t_texture;

    typedef struct packed {
        bit [MAG_W-1:0]  mag;
        bit [GRAD_W-1:0] gx;
        bit [GRAD_W-1:0] gy;
    } t_pixel;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] column;
        logic [7:0]          edge_res;
        logic                last;
    } t_mask;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [MAG_W-1:0] i_magnitude = '0;
    logic signed [GRAD_W-1:0] i_grad_x = '0;
    logic signed [GRAD_W-1:0] i_grad_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [ROW_BITS-1:0] o_row;
    logic [COL_BITS-1:0] o_column;
    logic [7:0] o_edge_res;
    logic o_last;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    gradient_non_maximum_suppression_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_magnitude(i_magnitude),
        .i_grad_x   (i_grad_x),
        .i_grad_y   (i_grad_y),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_row      (o_row),
        .o_column   (o_column),
        .o_edge_res (o_edge_res),
        .o_last     (o_last),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    t_pixel pixel_queue[$];
    t_mask  pending_masks[$];
    int     mismatches = 0;
    int     quiet_cycles = 0;

    int unsigned width_now = int'(WIDTH_RESET);
    int unsigned height_now = int'(HEIGHT_RESET);
    int unsigned row_now = 0;
    int unsigned col_now = 0;
    bit [MAG_W-1:0]  mag_older[MAX_COLS];
    bit [MAG_W-1:0]  mag_newer[MAX_COLS];
    bit [GRAD_W-1:0] gx_line[MAX_COLS];
    bit [GRAD_W-1:0] gy_line[MAX_COLS];
    t_pixel win[3][3];

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [7:0] edge_decision();
        longint gx, gy, s, sc, best_hi, best_lo;
        int hi_di, hi_dj, lo_di, lo_dj;
        bit first;
        gx = longint'($signed(win[1][1].gx));
        gy = longint'($signed(win[1][1].gy));
        first = 1'b1;
        best_hi = 0;
        best_lo = 0;
        hi_di = 0;
        hi_dj = 0;
        lo_di = 0;
        lo_dj = 0;
        if (gx == 0 && gy == 0) return NO_EDGE;
        for (int di = -1; di <= 1; di++) begin
            for (int dj = -1; dj <= 1; dj++) begin
                if (di != 0 || dj != 0) begin
                    s = di * gx + dj * gy;
                    sc = s * ((di != 0 && dj != 0) ? longint'(DIAG_WEIGHT) : AXIS_WEIGHT);
                    if (first || sc > best_hi) begin
                        best_hi = sc;
                        hi_di = di;
                        hi_dj = dj;
                    end
                    if (first || sc < best_lo) begin
                        best_lo = sc;
                        lo_di = di;
                        lo_dj = dj;
                    end
                    first = 1'b0;
                end
            end
        end
        return (win[1][1].mag > win[1 + hi_dj][1 + hi_di].mag &&
                win[1][1].mag > win[1 + lo_dj][1 + lo_di].mag) ? EDGE_VALUE : NO_EDGE;
    endfunction

    task automatic take_pixel(input t_pixel px);
        int unsigned slot;
        bit row_end, frame_end;
        t_mask m;
        slot = (col_now < MAX_COLS) ? col_now : MAX_COLS - 1;
        row_end = col_now >= width_now - 1;
        frame_end = row_end && row_now >= height_now - 1;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2].mag = mag_older[slot];
        win[0][2].gx = '0;
        win[0][2].gy = '0;
        win[1][2].mag = mag_newer[slot];
        win[1][2].gx = gx_line[slot];
        win[1][2].gy = gy_line[slot];
        win[2][2] = px;
        mag_older[slot] = mag_newer[slot];
        mag_newer[slot] = px.mag;
        gx_line[slot] = px.gx;
        gy_line[slot] = px.gy;
        if (row_now >= 2 && col_now >= 2) begin
            m.row = ROW_BITS'(row_now - 1);
            m.column = COL_BITS'(col_now - 1);
            m.edge_res = edge_decision();
            m.last = frame_end;
            pending_masks = {pending_masks, m};
        end
        if (row_end) begin
            col_now = 0;
            row_now = frame_end ? 0 : row_now + 1;
        end else begin
            col_now = col_now + 1;
        end
    endtask

    function automatic bit [GRAD_W-1:0] extreme_grad();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'h0001;
            4: return 16'hFFFF;
            default: return GRAD_W'($urandom);
        endcase
    endfunction

    function automatic t_pixel draw_pixel(input t_texture tex);
        t_pixel px;
        px.mag = MAG_W'($urandom);
        px.gx = GRAD_W'($urandom);
        px.gy = GRAD_W'($urandom);
        case (tex)
            TEX_TIES: begin
                px.mag = MAG_W'($urandom_range(0, 3));
                px.gx = GRAD_W'($urandom_range(0, 4) - 2);
                px.gy = GRAD_W'($urandom_range(0, 4) - 2);
            end
            TEX_EXTREME: begin
                case ($urandom_range(0, 2))
                    0: px.mag = '0;
                    1: px.mag = '1;
                    default: ;
                endcase
                px.gx = extreme_grad();
                px.gy = extreme_grad();
            end
            TEX_SPARSE: begin
                case ($urandom_range(0, 5))
                    0: begin
                        px.gx = '0;
                        px.gy = '0;
                    end
                    1: px.gx = '0;
                    2: px.gy = '0;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic queue_pixels(input int count, input t_texture tex);
        repeat (count) pixel_queue = {pixel_queue, draw_pixel(tex)};
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_now = clamp_dim(data[WIDTH_BITS-1:0], DIM_MIN, MAX_COLS);
        else if (idx == REG_IMAGE_HEIGHT)
            height_now = clamp_dim(data[HEIGHT_BITS-1:0], DIM_MIN, int'(HEIGHT_LIMIT));
        @(negedge i_clk);
    endtask

    task automatic settle();
        do @(negedge i_clk); while (pixel_queue.size() != 0 || pending_masks.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    int burst_left = 1;
    int gap_left = 0;
    int steady_left = 0;

    always @(posedge i_clk) begin : drive
        bit sent;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            sent = i_valid && !o_stall;
            if (sent) begin
                take_pixel(pixel_queue[0]);
                void'(pixel_queue.pop_front());
            end
            if (!i_valid || sent) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pixel_queue.size() != 0) begin
                    i_valid <= 1'b1;
                    i_magnitude <= pixel_queue[0].mag;
                    i_grad_x <= pixel_queue[0].gx;
                    i_grad_y <= pixel_queue[0].gy;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        if (steady_left != 0) begin
                            steady_left--;
                        end else begin
                            gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                                   : $urandom_range(0, 4);
                            if ($urandom_range(0, 9) == 0) steady_left = $urandom_range(4, 12);
                        end
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    bit stall_next = 1'b0;
    int run_left = 0;

    always @(posedge i_clk) begin : stall_pattern
        if (run_left != 0) begin
            run_left--;
        end else begin
            stall_next = ~stall_next;
            if (stall_next)
                run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 20)
                                                       : $urandom_range(0, 3);
            else
                run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                       : $urandom_range(0, 12);
        end
        i_stall <= stall_next;
    end

    always @(posedge i_clk) begin : observe
        t_mask seen, want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                seen.row = o_row;
                seen.column = o_column;
                seen.edge_res = o_edge_res;
                seen.last = o_last;
                if (pending_masks.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected mask, expected none, actual row %0d col %0d",
                             $time, seen.row, seen.column,
                             " edge %0d last %0d", seen.edge_res, seen.last);
                end else begin
                    want = pending_masks.pop_front();
                    if (seen.row !== want.row || seen.column !== want.column ||
                        seen.edge_res !== want.edge_res || seen.last !== want.last) begin
                        mismatches++;
                        $display("%0t: mask mismatch, expected row %0d col %0d edge %0d",
                                 $time, want.row, want.column, want.edge_res,
                                 " last %0d, actual row %0d col %0d edge %0d last %0d",
                                 want.last, seen.row, seen.column, seen.edge_res,
                                 seen.last);
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        int cols, rows, random_items;
        logic [CFG_DATA_BITS-1:0] wdata, hdata;
        t_pixel px;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry: one full row and a short second row, then narrow the frame
        queue_pixels(int'(WIDTH_RESET) + 3, TEX_FULL);
        settle();
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        queue_pixels(1 + 3, TEX_SPARSE);
        settle();

        write_reg(REG_IMAGE_WIDTH, 16'd5);
        write_reg(REG_IMAGE_HEIGHT, 16'd5);
        for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 5; c++) begin
                if (r == 2 && c == 2) px.mag = 16'hFFFF;
                else if ((r + c) % 3 == 0) px.mag = 16'h0000;
                else px.mag = MAG_W'(1000 * (r + c));
                px.gx = '0;
                px.gy = '0;
                if (r >= 1 && r <= 3 && c >= 1 && c <= 3) begin
                    case ((r - 1) * 3 + (c - 1))
                        0: begin px.gx = 16'h0001; px.gy = 16'hFFFF; end
                        1: begin px.gx = 16'h7FFF; px.gy = 16'h0000; end
                        2: begin px.gx = 16'h8000; px.gy = 16'h7FFF; end
                        // axis and diagonal scores tie exactly
                        3: begin px.gx = 16'd11585; px.gy = 16'd4799; end
                        4: begin px.gx = 16'h0000; px.gy = 16'h0000; end
                        5: begin px.gx = -16'sd4799; px.gy = -16'sd11585; end
                        6: begin px.gx = 16'h0000; px.gy = 16'h8000; end
                        7: begin px.gx = 16'h8000; px.gy = 16'h8000; end
                        default: begin px.gx = 16'h7FFF; px.gy = 16'h7FFF; end
                    endcase
                end
                pixel_queue = {pixel_queue, px};
            end
        end
        settle();

        // tall frame, then lower the height mid-frame so the next row closes it
        write_reg(REG_IMAGE_WIDTH, 16'h0000);
        write_reg(REG_IMAGE_HEIGHT, 16'h1000);
        queue_pixels(3 * 6, TEX_EXTREME);
        settle();
        write_reg(REG_IMAGE_HEIGHT, 16'hE002);
        queue_pixels(3, TEX_FULL);
        settle();

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0: cols = 3;
                1, 2: cols = $urandom_range(4, 8);
                3, 4, 5: cols = $urandom_range(9, 24);
                6: cols = $urandom_range(25, 64);
                default: cols = $urandom_range(3, 16);
            endcase
            rows = ($urandom_range(0, 3) == 0) ? 3 : $urandom_range(3, 7);
            wdata = CFG_DATA_BITS'($urandom & 32'hF000) | CFG_DATA_BITS'(cols);
            hdata = CFG_DATA_BITS'($urandom & 32'hE000) | CFG_DATA_BITS'(rows);
            if ($urandom_range(0, 9) == 0) begin
                cols = 3;
                wdata = CFG_DATA_BITS'($urandom & 32'hF000) |
                        CFG_DATA_BITS'($urandom_range(0, 2));
            end
            if ($urandom_range(0, 9) == 0) begin
                rows = 3;
                hdata = CFG_DATA_BITS'($urandom & 32'hE000) |
                        CFG_DATA_BITS'($urandom_range(0, 2));
            end
            if ($urandom_range(0, 5) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_DATA_BITS'($urandom));
            if ($urandom_range(0, 1)) begin
                write_reg(REG_IMAGE_WIDTH, wdata);
                write_reg(REG_IMAGE_HEIGHT, hdata);
            end else begin
                write_reg(REG_IMAGE_HEIGHT, hdata);
                write_reg(REG_IMAGE_WIDTH, wdata);
            end
            queue_pixels(cols * rows, t_texture'($urandom_range(0, 3)));
            random_items += cols * rows;
            settle();
        end

        if (mismatches == 0 && pending_masks.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/gnms_pkg.sv
rtl/gnms_ram.sv
rtl/gnms_fifo.sv
rtl/gnms_front.sv
rtl/gnms_back.sv
rtl/gradient_non_maximum_suppression_core.sv
bench/gradient_non_maximum_suppression_core_test.sv
